[sv/sldf_pkg.sv]
// ----------------------------------------------------------------------------
// Sync/length frame deframer package
// Shared constants, command codes and the deframer phase type.
// ----------------------------------------------------------------------------
`default_nettype none

package sldf_pkg;

  // Default header size field width in bytes and payload counter width.
  localparam int SIZE_FIELD_BYTES_DEF = 8;
  localparam int COUNT_BITS_DEF       = 32;

  // Sync pattern that opens every frame.
  localparam logic [7:0] SYNC_FIRST  = 8'h07;
  localparam logic [7:0] SYNC_SECOND = 8'h08;

  // Input command codes.
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Deframer phase.
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_SYNC2   = 2'd1,
    PH_HEADER  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

endpackage : sldf_pkg

`default_nettype wire

[sv/sync_length_frame_deframer.sv]
// ----------------------------------------------------------------------------
// Sync/length frame deframer
// Hunts for the 0x07 0x08 sync pair, gathers a two-size little-endian header
// and passes on the payload bytes with info/last/error tags.
// ----------------------------------------------------------------------------
`default_nettype none

// The deframer takes one byte transfer per clock and keeps that rate for as
// long as the result side does not stall. Every transfer first lands in an
// input register; when it is processed the frame state is updated and any
// result is written to the output register, from which it leaves. Sync bytes,
// header bytes, dropped headers and clear commands give no result; a header
// announcing a zero total size gives one empty item with frame_last set. A
// stall on the output while a result waits there holds the input register,
// which in turn stalls the input channel in the same cycle.

module sync_length_frame_deframer
  import sldf_pkg::*;
#(
  parameter int SIZE_FIELD_BYTES = SIZE_FIELD_BYTES_DEF,
  parameter int COUNT_BITS       = COUNT_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,

  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic       in_command,
  input  wire logic [7:0] in_data_byte,

  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic [7:0] out_payload_byte,
  output      logic       out_has_byte,
  output      logic       out_in_info_part,
  output      logic       out_frame_last,
  output      logic       out_size_error
);

  localparam int HDR_BYTES = 2 * SIZE_FIELD_BYTES;
  localparam int HC_W      = $clog2(HDR_BYTES);

  // Input register.
  logic       in_valid_r;
  logic       in_cmd_r;
  logic [7:0] in_byte_r;

  // Frame state.
  phase_t                  phase_r, phase_nxt;
  logic [HC_W-1:0]         hdr_cnt_r, hdr_cnt_nxt;
  logic [COUNT_BITS-1:0]   total_r, total_nxt;
  logic [COUNT_BITS-1:0]   info_r, info_nxt;
  logic [COUNT_BITS-1:0]   pcnt_r, pcnt_nxt;
  logic                    ovr_r, ovr_nxt;
  logic                    err_r, err_nxt;

  // Output register.
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_has_r;
  logic       out_info_r;
  logic       out_last_r;
  logic       out_err_r;

  // Result of the item being processed.
  logic       res_valid;
  logic [7:0] res_byte;
  logic       res_has;
  logic       res_info;
  logic       res_last;
  logic       res_err;

  // Header byte placement.
  logic                  is_total_byte;
  logic                  hdr_end;
  logic [HC_W-1:0]       lane_idx;
  logic [2:0]            lane;
  logic [63:0]           lane_val;
  logic [COUNT_BITS-1:0] lane_field;
  logic                  lane_over;
  logic [COUNT_BITS-1:0] total_acc;
  logic [COUNT_BITS-1:0] info_acc;
  logic                  ovr_acc;

  // Payload counting.
  logic [COUNT_BITS-1:0] pcnt_inc;
  logic                  pay_last;
  logic                  pay_info;

  logic proc;

  // The held item is processed when the output register is free or draining.
  assign proc     = in_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = in_valid_r & ~proc;

  // Input register: refilled whenever its item moves on or it is empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_cmd_r  <= in_command;
      in_byte_r <= in_data_byte;
    end
  end

  // Header byte lane: the byte is shifted into its little-endian position and
  // any bits beyond the counter width mark the header as oversize.
  assign is_total_byte = hdr_cnt_r < HC_W'(SIZE_FIELD_BYTES);
  assign hdr_end       = hdr_cnt_r == HC_W'(HDR_BYTES - 1);
  assign lane_idx      = is_total_byte ? hdr_cnt_r : hdr_cnt_r - HC_W'(SIZE_FIELD_BYTES);
  assign lane          = 3'(lane_idx);
  assign lane_val      = {56'd0, in_byte_r} << {lane, 3'b000};
  assign lane_field    = lane_val[COUNT_BITS-1:0];
  assign lane_over     = (lane_val >> COUNT_BITS) != 64'd0;
  assign total_acc     = is_total_byte ? (total_r | lane_field) : total_r;
  assign info_acc      = is_total_byte ? info_r : (info_r | lane_field);
  assign ovr_acc       = ovr_r | lane_over;

  // Payload byte tags.
  assign pcnt_inc = pcnt_r + COUNT_BITS'(1);
  assign pay_last = pcnt_inc >= total_r;
  assign pay_info = pcnt_r < info_r;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (proc) begin
      if (in_cmd_r == CMD_CLEAR) begin
        phase_nxt = PH_HUNT;
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
            if (in_byte_r == SYNC_FIRST) phase_nxt = PH_SYNC2;
          end
          PH_SYNC2: begin
            if (in_byte_r == SYNC_SECOND) phase_nxt = PH_HEADER;
          end
          PH_HEADER: begin
            if (hdr_end) begin
              if (ovr_acc || total_acc == '0) phase_nxt = PH_HUNT;
              else phase_nxt = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            if (pay_last) phase_nxt = PH_HUNT;
          end
          default: phase_nxt = PH_HUNT;
        endcase
      end
    end
  end

  // Frame counters and the result of the current item.
  always_comb begin
    hdr_cnt_nxt = hdr_cnt_r;
    total_nxt   = total_r;
    info_nxt    = info_r;
    pcnt_nxt    = pcnt_r;
    ovr_nxt     = ovr_r;
    err_nxt     = err_r;
    res_valid   = 1'b0;
    res_byte    = 8'd0;
    res_has     = 1'b0;
    res_info    = 1'b0;
    res_last    = 1'b0;
    res_err     = 1'b0;
    if (proc) begin
      if (in_cmd_r == CMD_CLEAR) begin
        hdr_cnt_nxt = '0;
        total_nxt   = '0;
        info_nxt    = '0;
        pcnt_nxt    = '0;
        ovr_nxt     = 1'b0;
        err_nxt     = 1'b0;
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
          end
          PH_SYNC2: begin
            // Every frame starts its sizes and counts from zero.
            if (in_byte_r == SYNC_SECOND) begin
              hdr_cnt_nxt = '0;
              total_nxt   = '0;
              info_nxt    = '0;
              pcnt_nxt    = '0;
              ovr_nxt     = 1'b0;
              err_nxt     = 1'b0;
            end
          end
          PH_HEADER: begin
            total_nxt = total_acc;
            info_nxt  = info_acc;
            ovr_nxt   = ovr_acc;
            if (hdr_end) begin
              hdr_cnt_nxt = '0;
              pcnt_nxt    = '0;
              err_nxt     = total_acc < info_acc;
              // An empty frame still reports its end unless the header is dropped.
              if (!ovr_acc && total_acc == '0) begin
                res_valid = 1'b1;
                res_last  = 1'b1;
                res_err   = info_acc != '0;
              end
            end else begin
              hdr_cnt_nxt = hdr_cnt_r + HC_W'(1);
            end
          end
          PH_PAYLOAD: begin
            pcnt_nxt  = pcnt_inc;
            res_valid = 1'b1;
            res_byte  = in_byte_r;
            res_has   = 1'b1;
            res_info  = pay_info;
            res_last  = pay_last;
            res_err   = err_r;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      hdr_cnt_r <= '0;
      total_r   <= '0;
      info_r    <= '0;
      pcnt_r    <= '0;
      ovr_r     <= 1'b0;
      err_r     <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      total_r   <= total_nxt;
      info_r    <= info_nxt;
      pcnt_r    <= pcnt_nxt;
      ovr_r     <= ovr_nxt;
      err_r     <= err_nxt;
    end
  end

  // Output register: loaded by a processed item, emptied by a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= res_valid;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      out_byte_r <= res_byte;
      out_has_r  <= res_has;
      out_info_r <= res_info;
      out_last_r <= res_last;
      out_err_r  <= res_err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_has_byte     = out_has_r;
  assign out_in_info_part = out_info_r;
  assign out_frame_last   = out_last_r;
  assign out_size_error   = out_err_r;

endmodule : sync_length_frame_deframer

`default_nettype wire

[sim/tb_sync_length_frame_deframer.sv]
// ----------------------------------------------------------------------------
// Sync/length frame deframer testbench
// Drives byte and clear transfers into the deframer under random sender and
// receiver idling and predicts every result with a cycle-free model of the
// frame state. Results are checked in order against the predicted queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sync_length_frame_deframer;
  import sldf_pkg::*;

  localparam int SFB          = SIZE_FIELD_BYTES_DEF;
  localparam int CB           = COUNT_BITS_DEF;
  localparam int HDR_BYTES    = 2 * SFB;
  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [63:0] CNT_MASK = (CB >= 64) ? '1 : ((64'd1 << CB) - 64'd1);

  // One result transfer as the deframer presents it.
  typedef struct packed {
    logic [7:0] payload;
    logic       has_byte;
    logic       info_part;
    logic       last;
    logic       size_err;
  } frame_item_t;

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic       in_command       = CMD_DATA;
  logic [7:0] in_data_byte     = 8'h00;
  logic       out_stall        = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_payload_byte;
  logic       out_has_byte;
  logic       out_in_info_part;
  logic       out_frame_last;
  logic       out_size_error;

  // Predicted frame state.
  phase_t         dfr_phase;
  logic [3:0]     hdr_idx;
  logic [CB-1:0]  total_len;
  logic [CB-1:0]  info_len;
  logic [CB-1:0]  pay_count;
  logic           oversize;

  frame_item_t    expected_q[$];
  int             mismatches    = 0;
  int             items_sent    = 0;
  int             cycle_count   = 0;
  int unsigned    send_idle_pct = 29;
  int unsigned    recv_idle_pct = 57;
  int             hold_req      = 0;
  int             hold_left     = 0;

  sync_length_frame_deframer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_has_byte     (out_has_byte),
    .out_in_info_part (out_in_info_part),
    .out_frame_last   (out_frame_last),
    .out_size_error   (out_size_error)
  );

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic void reset_model();
    dfr_phase = PH_HUNT;
    hdr_idx   = '0;
    total_len = '0;
    info_len  = '0;
    pay_count = '0;
    oversize  = 1'b0;
  endfunction

  // Advances the predicted frame state by one accepted transfer. Returns 1
  // when the transfer yields a result, which is written to item.
  function automatic bit deframe_byte(input logic cmd, input logic [7:0] b,
                                      output frame_item_t item);
    int          pos;
    logic [63:0] shifted;
    bit          emitted;
    emitted = 1'b0;
    item    = '0;
    if (cmd == CMD_CLEAR) begin
      reset_model();
    end else begin
      case (dfr_phase)
        PH_HUNT: begin
          if (b == SYNC_FIRST) dfr_phase = PH_SYNC2;
        end
        PH_SYNC2: begin
          // Only the second sync byte moves on; anything else is ignored.
          if (b == SYNC_SECOND) begin
            dfr_phase = PH_HEADER;
            hdr_idx   = '0;
            total_len = '0;
            info_len  = '0;
            pay_count = '0;
            oversize  = 1'b0;
          end
        end
        PH_HEADER: begin
          // Little-endian size bytes: total first, then info.
          pos     = (int'(hdr_idx) < SFB) ? int'(hdr_idx) : int'(hdr_idx) - SFB;
          shifted = 64'(b) << (8 * pos);
          if ((shifted & ~CNT_MASK) != 64'd0) oversize = 1'b1;
          if (int'(hdr_idx) < SFB) total_len = total_len | shifted[CB-1:0];
          else info_len = info_len | shifted[CB-1:0];
          if (int'(hdr_idx) + 1 >= HDR_BYTES) begin
            hdr_idx   = '0;
            pay_count = '0;
            if (oversize) begin
              dfr_phase = PH_HUNT;
            end else if (total_len == '0) begin
              // Empty frame: a single end marker without a byte.
              dfr_phase     = PH_HUNT;
              item.last     = 1'b1;
              item.size_err = (info_len != '0);
              emitted       = 1'b1;
            end else begin
              dfr_phase = PH_PAYLOAD;
            end
          end else begin
            hdr_idx = hdr_idx + 4'd1;
          end
        end
        default: begin
          item.payload   = b;
          item.has_byte  = 1'b1;
          item.info_part = (pay_count < info_len);
          item.size_err  = (total_len < info_len);
          pay_count      = pay_count + 1'b1;
          item.last      = (pay_count >= total_len);
          if (item.last) dfr_phase = PH_HUNT;
          emitted = 1'b1;
        end
      endcase
    end
    return emitted;
  endfunction

  // Result checking and prediction of accepted input transfers.
  always @(posedge clk) begin : result_check
    frame_item_t seen;
    frame_item_t want;
    frame_item_t pred;
    if (!rst_n) begin
      reset_model();
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen = {out_payload_byte, out_has_byte, out_in_info_part, out_frame_last,
                out_size_error};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("cycle %0d: unexpected byte %02h has %0b info %0b last %0b err %0b",
                     cycle_count, seen.payload, seen.has_byte, seen.info_part, seen.last,
                     seen.size_err);
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("cycle %0d: expected byte %02h has %0b info %0b last %0b err %0b",
                       cycle_count, want.payload, want.has_byte, want.info_part,
                       want.last, want.size_err);
              $display("  got byte %02h has %0b info %0b last %0b err %0b",
                       seen.payload, seen.has_byte, seen.info_part, seen.last,
                       seen.size_err);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (deframe_byte(in_command, in_data_byte, pred)) expected_q.push_back(pred);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Offers one transfer after a random number of idle cycles and waits for it.
  task automatic send_item(input logic cmd, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_clear();
    send_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
  endtask

  // Sends a sync pair with gap_n junk bytes between its halves, the first
  // hdr_n header bytes and pay_n random payload bytes.
  task automatic send_frame(input logic [63:0] tot, input logic [63:0] inf,
                            input int gap_n, input int hdr_n, input int pay_n);
    logic [63:0] field;
    logic [7:0]  junk;
    send_item(CMD_DATA, SYNC_FIRST);
    repeat (gap_n) begin
      junk = 8'($urandom_range(0, 255));
      if (junk == SYNC_SECOND) junk = 8'h00;
      send_item(CMD_DATA, junk);
    end
    send_item(CMD_DATA, SYNC_SECOND);
    for (int i = 0; i < hdr_n; i++) begin
      field = (i < SFB) ? tot : inf;
      send_item(CMD_DATA, field[8 * (i % SFB) +: 8]);
    end
    repeat (pay_n) send_item(CMD_DATA, 8'($urandom_range(0, 255)));
  endtask

  // Stops offering until every predicted result has arrived and the pipeline
  // has had time to finish any transfer that gives no result.
  task automatic pause_sender();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Noise before sync, a stray second sync while hunting, and a repeated
  // first sync while waiting for the second.
  task automatic test_sync_hunt();
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, SYNC_SECOND);
    send_item(CMD_DATA, SYNC_FIRST);
    send_frame(64'd2, 64'd1, 1, HDR_BYTES, 2);
  endtask

  // Zero total size, with and without an info size.
  task automatic test_zero_length();
    send_frame(64'd0, 64'd0, 0, HDR_BYTES, 0);
    send_frame(64'd0, 64'd5, 0, HDR_BYTES, 0);
  endtask

  // Info size above the total size, including the largest countable info size.
  task automatic test_size_error();
    send_frame(64'd2, 64'd3, 0, HDR_BYTES, 2);
    send_frame(64'd3, {32'h0, 32'hFFFF_FFFF}, 0, HDR_BYTES, 3);
  endtask

  // Headers with size bits beyond the counter are dropped; hunting resumes.
  task automatic test_oversize();
    send_frame(64'h0000_0001_0000_0001, 64'd0, 0, HDR_BYTES, 0);
    send_frame(64'd1, 64'hFF00_0000_0000_0000, 0, HDR_BYTES, 0);
    send_item(CMD_DATA, 8'h55);
    send_frame(64'd1, 64'd0, 0, HDR_BYTES, 1);
  endtask

  // Clear while hunting, inside a header and inside a payload.
  task automatic test_clear();
    send_clear();
    send_frame(64'd3, 64'd1, 0, 5, 0);
    send_clear();
    send_frame(64'd3, 64'd1, 0, HDR_BYTES, 1);
    send_clear();
    send_frame(64'd1, 64'd1, 0, HDR_BYTES, 1);
  endtask

  // The receiver holds off long enough for the deframer to stall its input.
  task automatic test_backpressure();
    hold_req = HOLD_CYCLES;
    send_frame(64'd40, 64'd10, 0, HDR_BYTES, 40);
    pause_sender();
  endtask

  // One random frame: mostly well formed with random sizes and content, some
  // oversize or cut-off headers and long frames broken off by a clear.
  task automatic send_random_frame();
    int          kind;
    int          gap_n;
    int          hdr_n;
    int          pay_n;
    int          k;
    logic [63:0] tot;
    logic [63:0] inf;
    kind  = $urandom_range(0, 99);
    gap_n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    hdr_n = HDR_BYTES;
    if ($urandom_range(0, 3) == 0) send_item(CMD_DATA, 8'($urandom_range(0, 255)));
    if (kind < 6) tot = 64'd0;
    else if (kind < 70) tot = 64'($urandom_range(1, 8));
    else if (kind < 84) tot = 64'($urandom_range(9, 40));
    else tot = {32'h0, $urandom()};
    if ($urandom_range(0, 4) == 0) inf = {32'h0, $urandom()};
    else inf = 64'($urandom_range(0, (tot > 64'd40) ? 42 : int'(tot) + 2));
    pay_n = (tot > 64'd40) ? $urandom_range(1, 6) : int'(tot);
    if (kind >= 92 && kind < 96) begin
      // Upper size byte set in one of the two fields.
      k = $urandom_range(CB / 8, SFB - 1);
      if ($urandom_range(0, 1) == 0) tot[8 * k +: 8] = 8'($urandom_range(1, 255));
      else inf[8 * k +: 8] = 8'($urandom_range(1, 255));
      pay_n = 0;
    end else if (kind >= 96) begin
      hdr_n = $urandom_range(0, HDR_BYTES - 1);
      pay_n = 0;
    end
    send_frame(tot, inf, gap_n, hdr_n, pay_n);
    if (hdr_n < HDR_BYTES || tot > 64'd40) send_clear();
  endtask

  task automatic test_random_frames(input int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) send_random_frame();
  endtask

  // Test sequence.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sync_hunt();
    test_zero_length();
    test_size_error();
    test_oversize();
    test_clear();
    test_backpressure();
    send_idle_pct = 29;
    recv_idle_pct = 57;
    test_random_frames(RANDOM_ITEMS / 3);
    send_idle_pct = 57;
    recv_idle_pct = 29;
    test_random_frames(RANDOM_ITEMS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(RANDOM_ITEMS / 3);
    pause_sender();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
sv/sldf_pkg.sv
sv/sync_length_frame_deframer.sv
sim/tb_sync_length_frame_deframer.sv
